// ===== rtl/tcfe_pkg.sv =====
// shared types and constants of the timestamped cobs frame encoder
package tcfe_pkg;

  // frame terminator and the zero byte that closes a cobs group
  localparam logic [7:0] FRAME_TERM = 8'h00;

  // byte slots of one item: four timestamp bytes, then the payload byte
  localparam logic [2:0] SEL_TS_MSB = 3'd0;
  localparam logic [2:0] SEL_TS_B2  = 3'd1;
  localparam logic [2:0] SEL_TS_B1  = 3'd2;
  localparam logic [2:0] SEL_TS_LSB = 3'd3;
  localparam logic [2:0] SEL_DATA   = 3'd4;

  // register index decoded from paddr[2]
  localparam logic REG_TS_OFFSET = 1'b0;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC,
    ST_CODE,
    ST_DATA,
    ST_TERM,
    ST_DONE
  } tcfe_state_e;

endpackage

// ===== rtl/tcfe_byte_if.sv =====
// item channels: packet bytes in, encoded frame bytes out
interface tcfe_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic [31:0] now_ms;

  modport source (output valid, data_byte, first_byte, last_byte, now_ms, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, now_ms, output ready);
endinterface

interface tcfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       frame_end;

  modport source (output valid, out_byte, last_of_run, frame_end, input ready);
  modport sink   (input valid, out_byte, last_of_run, frame_end, output ready);
endinterface

// ===== rtl/timestamped_cobs_frame_encoder.sv =====
// timestamped cobs frame encoder: sequencer, group memory and output register
//
//  channel  dir  handshake        payload
//  in_i     in   valid/ready      data_byte, first_byte, last_byte, now_ms
//  out_o    out  valid/ready      out_byte, last_of_run, frame_end
//  apb      in   psel/penable     paddr, pwdata, prdata (timestamp_offset at 0x0)
//
// a plain non-zero byte is held in the group memory; a byte that closes a group
// first emits each result (code byte plus held bytes), and with a non-zero
// timestamp_offset the first byte of a packet walks four extra timestamp slots
// through the same path. the group memory has one read port with registered
// data, which sets the one byte per cycle flush rate. results pass a one-deep
// pending stage so the last one can carry last_of_run; a stalled output holds
// the sequencer in place. reset clears control state only, not the group memory.
module timestamped_cobs_frame_encoder
  import tcfe_pkg::*;
#(
  parameter int MAX_PACKET = 58
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  tcfe_in_if.sink           in_i,
  tcfe_out_if.source        out_o
);

  localparam int GroupDepth = MAX_PACKET + 4;
  localparam int GcW        = $clog2(GroupDepth + 1);
  localparam int AddrW      = $clog2(GroupDepth);
  localparam int PcW        = $clog2(MAX_PACKET + 1);

  // configuration register
  logic [31:0] ts_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_offset_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TS_OFFSET)) begin
      ts_offset_q <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TS_OFFSET) ? ts_offset_q : '0;

  // sequencer and packet state
  tcfe_state_e          state_q, state_d;
  logic [GcW-1:0]       gc_q, gc_d;
  logic [PcW-1:0]       pc_q, pc_d;
  logic                 in_pkt_q, in_pkt_d;
  logic [2:0]           sel_q, sel_d;
  logic [AddrW-1:0]     k_q, k_d;
  logic                 fin_q, fin_d;
  logic                 has_data_q, has_data_d;
  logic                 last_q, last_d;
  logic [31:0]          ts_q, ts_d;
  logic [7:0]           data_q, data_d;

  // pending result and output register
  logic                 pend_valid_q, pend_valid_d;
  logic [7:0]           pend_byte_q, pend_byte_d;
  logic                 pend_term_q, pend_term_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_byte_q, out_byte_d;
  logic                 out_last_q, out_last_d;
  logic                 out_term_q, out_term_d;

  // group memory
  logic [7:0]           group_mem [GroupDepth];
  logic                 wr_en;
  logic [7:0]           wr_data;
  logic                 rd_en;
  logic [AddrW-1:0]     rd_addr;
  logic [7:0]           rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      group_mem[gc_q[AddrW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= group_mem[rd_addr];
    end
  end

  logic       accept;
  logic       out_free;
  logic       emit_req;
  logic       emit_go;
  logic       stall;
  logic [7:0] emit_byte;
  logic       emit_term;
  logic       final_push;
  logic [7:0] cur_byte;
  logic       bytes_done;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign stall    = pend_valid_q && !out_free;

  // current byte slot: timestamp msb first, then payload
  always_comb begin
    case (sel_q)
      SEL_TS_MSB: cur_byte = ts_q[31:24];
      SEL_TS_B2:  cur_byte = ts_q[23:16];
      SEL_TS_B1:  cur_byte = ts_q[15:8];
      SEL_TS_LSB: cur_byte = ts_q[7:0];
      default:    cur_byte = data_q;
    endcase
  end

  assign bytes_done = (sel_q > SEL_DATA) || ((sel_q == SEL_DATA) && !has_data_q);

  // next state and datapath control
  always_comb begin
    state_d    = state_q;
    gc_d       = gc_q;
    pc_d       = pc_q;
    in_pkt_d   = in_pkt_q;
    sel_d      = sel_q;
    k_d        = k_q;
    fin_d      = fin_q;
    has_data_d = has_data_q;
    last_d     = last_q;
    ts_d       = ts_q;
    data_d     = data_q;
    in_i.ready = 1'b0;
    wr_en      = 1'b0;
    wr_data    = cur_byte;
    rd_en      = 1'b0;
    rd_addr    = '0;
    emit_req   = 1'b0;
    emit_byte  = FRAME_TERM;
    emit_term  = 1'b0;
    final_push = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          ts_d   = in_i.now_ms + ts_offset_q;
          data_d = in_i.data_byte;
          last_d = in_i.last_byte;
          fin_d  = 1'b0;
          if (in_i.first_byte) begin
            gc_d     = '0;
            in_pkt_d = 1'b0;
            if (ts_offset_q != '0) begin
              in_pkt_d   = !in_i.last_byte;
              has_data_d = 1'b1;
              pc_d       = in_i.last_byte ? '0 : PcW'(1);
              sel_d      = SEL_TS_MSB;
              state_d    = ST_ENC;
            end else begin
              pc_d = '0;
            end
          end else if (in_pkt_q) begin
            has_data_d = (pc_q < PcW'(MAX_PACKET));
            pc_d       = in_i.last_byte ? '0 :
                         (pc_q < PcW'(MAX_PACKET)) ? pc_q + PcW'(1) : pc_q;
            in_pkt_d   = !in_i.last_byte;
            sel_d      = SEL_DATA;
            state_d    = ST_ENC;
          end
        end
      end

      // one byte slot per cycle: hold non-zero bytes, flush on zero
      ST_ENC: begin
        if (bytes_done) begin
          if (last_q) begin
            fin_d   = 1'b1;
            state_d = ST_CODE;
          end else begin
            state_d = ST_DONE;
          end
        end else if (cur_byte == FRAME_TERM) begin
          state_d = ST_CODE;
        end else begin
          wr_en = 1'b1;
          gc_d  = gc_q + GcW'(1);
          sel_d = sel_q + 3'd1;
        end
      end

      // code byte of the group, prefetch the first held byte
      ST_CODE: begin
        emit_req  = 1'b1;
        emit_byte = 8'(gc_q) + 8'd1;
        if (!stall) begin
          rd_en   = 1'b1;
          rd_addr = '0;
          k_d     = '0;
          if (gc_q == '0) begin
            if (fin_q) begin
              state_d = ST_TERM;
            end else begin
              sel_d   = sel_q + 3'd1;
              state_d = ST_ENC;
            end
          end else begin
            state_d = ST_DATA;
          end
        end
      end

      // held bytes, one memory read per cycle unless the output stalls
      ST_DATA: begin
        emit_req  = 1'b1;
        emit_byte = rd_q;
        if (!stall) begin
          if (GcW'(k_q) + GcW'(1) == gc_q) begin
            gc_d = '0;
            if (fin_q) begin
              state_d = ST_TERM;
            end else begin
              sel_d   = sel_q + 3'd1;
              state_d = ST_ENC;
            end
          end else begin
            k_d     = k_q + AddrW'(1);
            rd_en   = 1'b1;
            rd_addr = k_q + AddrW'(1);
          end
        end
      end

      ST_TERM: begin
        emit_req  = 1'b1;
        emit_byte = FRAME_TERM;
        emit_term = 1'b1;
        if (!stall) begin
          state_d = ST_DONE;
        end
      end

      // release the held result as the last of this item
      ST_DONE: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          final_push = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign emit_go = emit_req && !stall;

  // pending stage and output register
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_byte_d  = pend_byte_q;
    pend_term_d  = pend_term_q;
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_term_d   = out_term_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if ((emit_go && pend_valid_q) || final_push) begin
      out_valid_d = 1'b1;
      out_byte_d  = pend_byte_q;
      out_term_d  = pend_term_q;
      out_last_d  = final_push;
    end
    if (emit_go) begin
      pend_valid_d = 1'b1;
      pend_byte_d  = emit_byte;
      pend_term_d  = emit_term;
    end else if (final_push) begin
      pend_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      gc_q         <= '0;
      pc_q         <= '0;
      in_pkt_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      gc_q         <= gc_d;
      pc_q         <= pc_d;
      in_pkt_q     <= in_pkt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sel_q       <= sel_d;
    k_q         <= k_d;
    fin_q       <= fin_d;
    has_data_q  <= has_data_d;
    last_q      <= last_d;
    ts_q        <= ts_d;
    data_q      <= data_d;
    pend_byte_q <= pend_byte_d;
    pend_term_q <= pend_term_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_term_q  <= out_term_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.last_of_run = out_last_q;
  assign out_o.frame_end   = out_term_q;

`ifndef SYNTHESIS
  // held bytes never overrun the group memory
  assert property (@(posedge clk_i) disable iff (!rst_ni) gc_q <= GcW'(GroupDepth))
    else $error("group count beyond group depth");

  // a terminator result always carries the zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_term_q || (out_byte_q == FRAME_TERM)))
    else $error("frame_end on a non-zero byte");

  // no result is left pending once the block takes a new item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("pending result left behind in idle");

  // a packet started with logging disabled never opens a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.first_byte && (ts_offset_q == '0)) |=>
      (!in_pkt_q && (state_q == ST_IDLE)))
    else $error("dropped packet opened a frame");
`endif

endmodule
